// ----- rtl/core/sha256_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and the engine state type.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage
`default_nettype wire

// ----- rtl/core/sha256_hash_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Byte-stream SHA-256 with padding and an eight-word digest output.
// ----------------------------------------------------------------------------
// A byte transaction that does not complete a block leaves the engine idle and
// ready. The 64th byte of a block starts a compression: the sixteen schedule
// words are loaded from the byte memory (one byte a cycle, through a registered
// read), 64 rounds run at one round per cycle with the schedule in a 16-word
// shift line, and the eight working words are folded into the chaining value
// before the next transaction is accepted. A last transaction writes the
// padding one byte a cycle from the first free position to the end of the
// block and compresses it; when the pad byte lands at position 56 or later a
// second padding block and a second compression follow before the eight
// digest words are offered. The next transaction is accepted the cycle after
// the final word has been taken. Bytes sit in a 64-entry memory.
module sha256_hash_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_msg_byte,
    input  wire logic        i_has_data,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic             o_word_last
);
    import sha256_pkg::*;

    t_state r_state, n_state;

    logic [7:0]  r_blk [64];
    logic [7:0]  r_blk_q;
    logic        blk_we;
    logic [5:0]  blk_wa, blk_ra;
    logic [7:0]  blk_wd;

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_sh [16];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [6:0]  r_cnt;
    logic [5:0]  r_pos;
    logic [23:0] r_word;
    logic        r_tail;
    logic        r_mark;
    logic        r_lenblk;

    logic        acc;
    logic [5:0]  pad_start;
    logic [5:0]  len_idx;
    logic [63:0] len_sh;
    logic [31:0] w_cur, s0, s1, t1, t2, e, a;
    logic [5:0]  rnd;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // Byte memory.
    always_ff @(posedge i_clk) begin
        if (blk_we) r_blk[blk_wa] <= blk_wd;
        r_blk_q <= r_blk[blk_ra];
    end

    assign acc = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE);
    assign rnd = r_cnt[5:0];
    assign pad_start = i_has_data ? r_fill + 6'd1 : r_fill;
    // Length bytes go out most significant first from position 56.
    assign len_idx = 6'd63 - r_pos;
    assign len_sh = r_bits >> {len_idx[2:0], 3'b000};

    // Tap 0 holds W[t] up to round 15, then W[t-16] with W[t-1] in tap 15.
    always_comb begin
        s0 = rotr(r_sh[1], 7) ^ rotr(r_sh[1], 18) ^ (r_sh[1] >> 3);
        s1 = rotr(r_sh[14], 17) ^ rotr(r_sh[14], 19) ^ (r_sh[14] >> 10);
        w_cur = (rnd < 6'd16) ? r_sh[0] : (r_sh[0] + s0 + r_sh[9] + s1);
        e = r_v[4];
        a = r_v[0];
        t1 = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
             + ((e & r_v[5]) ^ (~e & r_v[6])) + ROUND_K[rnd] + w_cur;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
             + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_comb begin
        n_state = r_state;
        blk_we = 1'b0;
        blk_wa = r_fill;
        blk_wd = i_msg_byte;
        blk_ra = r_cnt[5:0];
        case (r_state)
            ST_IDLE: begin
                if (acc && i_has_data) blk_we = 1'b1;
                if (acc && i_has_data && r_fill == 6'd63) n_state = ST_LOAD;
                else if (acc && i_last) n_state = ST_PAD;
            end
            ST_PAD: begin
                blk_we = 1'b1;
                blk_wa = r_pos;
                if (r_mark) blk_wd = PAD_BYTE;
                else if (r_lenblk && r_pos >= LEN_POS) blk_wd = len_sh[7:0];
                else blk_wd = 8'h00;
                if (r_pos == 6'd63) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (r_cnt == 7'd64) n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (r_cnt == 7'd63) n_state = ST_FOLD;
            end
            ST_FOLD: begin
                if (r_cnt == 7'd7) begin
                    if (r_tail && r_lenblk) n_state = ST_EMIT;
                    else if (r_tail) n_state = ST_PAD;
                    else n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_ready && r_cnt == 7'd7) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid = (r_state == ST_EMIT);
    assign o_digest_word = r_h[r_cnt[2:0]];
    assign o_word_last = (r_cnt[2:0] == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // r_mark: the 0x80 byte still has to be placed at the start of the pad.
    // r_lenblk: the block being padded or compressed carries the length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_bits <= '0;
            r_cnt <= '0;
            r_pos <= '0;
            r_tail <= 1'b0;
            r_mark <= 1'b0;
            r_lenblk <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= INIT_H[i];
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (acc) begin
                        r_tail <= i_last;
                        r_mark <= i_last;
                        r_pos <= pad_start;
                        r_lenblk <= !(i_has_data && r_fill == 6'd63)
                                    && (pad_start < LEN_POS);
                        if (i_has_data) begin
                            r_fill <= r_fill + 6'd1;
                            r_bits <= r_bits + 64'd8;
                        end
                    end
                end
                ST_PAD: begin
                    r_pos <= r_pos + 6'd1;
                    r_mark <= 1'b0;
                end
                ST_LOAD: begin
                    // Bytes arrive in the cycle after their address.
                    if (r_cnt != 7'd0) begin
                        r_word <= {r_word[15:0], r_blk_q};
                        if (r_cnt[1:0] == 2'd0) begin
                            for (int i = 0; i < 15; i++) r_sh[i] <= r_sh[i+1];
                            r_sh[15] <= {r_word, r_blk_q};
                        end
                    end
                    if (r_cnt == 7'd64) begin
                        r_cnt <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) r_sh[i] <= r_sh[i+1];
                    r_sh[15] <= w_cur;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    if (r_cnt == 7'd63) r_cnt <= '0;
                    else r_cnt <= r_cnt + 7'd1;
                end
                ST_FOLD: begin
                    r_h[r_cnt[2:0]] <= r_h[r_cnt[2:0]] + r_v[r_cnt[2:0]];
                    if (r_cnt == 7'd7) begin
                        r_cnt <= '0;
                        r_fill <= '0;
                        r_pos <= '0;
                        // A further pad block always ends with the length.
                        r_lenblk <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                ST_EMIT: begin
                    if (i_ready) begin
                        if (r_cnt == 7'd7) begin
                            r_cnt <= '0;
                            r_tail <= 1'b0;
                            r_fill <= '0;
                            r_bits <= '0;
                            for (int i = 0; i < 8; i++) r_h[i] <= INIT_H[i];
                        end else begin
                            r_cnt <= r_cnt + 7'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while digest pending");
    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_word_last) |=> o_ready)
        else $error("engine not idle after final word");
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_word_last) |=> o_valid)
        else $error("digest words interrupted");

endmodule
`default_nettype wire
